### rtl/core/tsg_pkg.sv
package tsg_pkg;

   localparam int STACK_DEPTH  = 64;
   localparam int CORDIC_STEPS = 16;
   localparam int ATAN_LEN     = 24;

   localparam int LVL_W   = $clog2(STACK_DEPTH + 1);
   localparam int SADDR_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int STEP_W  = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
   localparam int CW      = 34;               // CORDIC vector width, Q2.30 plus headroom
   localparam int PROD_W  = 24 + 1 + CW;
   localparam int ENTRY_W = 32 + 32 + 16;

   localparam logic [7:0]  SYM_LEFT  = 8'h2B;
   localparam logic [7:0]  SYM_RIGHT = 8'h2D;
   localparam logic [7:0]  SYM_PUSH  = 8'h5B;
   localparam logic [7:0]  SYM_POP   = 8'h5D;
   localparam logic [7:0]  SYM_SPACE = 8'h20;

   localparam logic [15:0] HEADING_RESET = 16'd49152;
   localparam logic [23:0] STEP_RESET    = 24'd65536;
   localparam logic [15:0] TURN_RESET    = 16'd4096;
   localparam logic [CW-1:0] GAIN_Q30    = CW'(652032874);

   localparam logic [1:0] ST_SEGMENT   = 2'd0;
   localparam logic [1:0] ST_OVERFLOW  = 2'd1;
   localparam logic [1:0] ST_UNDERFLOW = 2'd2;

   localparam logic REG_STEP_LENGTH = 1'b0;
   localparam logic REG_TURN_ANGLE  = 1'b1;

   typedef enum logic [3:0] {
      FSM_IDLE, FSM_DECODE, FSM_POP_WAIT, FSM_CORDIC, FSM_MUL_X, FSM_MUL_Y,
      FSM_ROUND, FSM_EMIT
   } fsm_type;

   typedef enum logic [2:0] {
      CLS_LEFT, CLS_RIGHT, CLS_PUSH, CLS_POP, CLS_SPACE, CLS_MOVE
   } sym_class_type;

   typedef struct packed {
      logic       accept;
      logic       head_inc;
      logic       head_dec;
      logic       push;
      logic       pop_rd;
      logic       pop_load;
      logic       cordic_init;
      logic       cordic_step;
      logic       mul_x;
      logic       mul_y;
      logic       round_y;
      logic       load_out;
   } cmd_type;

   typedef struct packed {
      sym_class_type sym_class;
      logic          stack_full;
      logic          stack_empty;
      logic          cordic_last;
   } stat_type;

   function automatic logic [31:0] atan_lookup(input logic [STEP_W-1:0] idx);
      logic [31:0] v;
      unique case (5'(idx))
         5'd0:  v = 32'h20000000;
         5'd1:  v = 32'h12E4051E;
         5'd2:  v = 32'h09FB385B;
         5'd3:  v = 32'h051111D4;
         5'd4:  v = 32'h028B0D43;
         5'd5:  v = 32'h0145D7E1;
         5'd6:  v = 32'h00A2F61E;
         5'd7:  v = 32'h00517C55;
         5'd8:  v = 32'h0028BE53;
         5'd9:  v = 32'h00145F2F;
         5'd10: v = 32'h000A2F98;
         5'd11: v = 32'h000517CC;
         5'd12: v = 32'h00028BE6;
         5'd13: v = 32'h000145F3;
         5'd14: v = 32'h0000A2FA;
         5'd15: v = 32'h0000517D;
         5'd16: v = 32'h000028BE;
         5'd17: v = 32'h0000145F;
         5'd18: v = 32'h00000A30;
         5'd19: v = 32'h00000518;
         5'd20: v = 32'h0000028C;
         5'd21: v = 32'h00000146;
         5'd22: v = 32'h000000A3;
         5'd23: v = 32'h00000051;
         default: v = 32'h0;
      endcase
      return v;
   endfunction

endpackage

### rtl/core/tsg_ram.sv
module tsg_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/tsg_ctrl.sv
module tsg_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   input  tsg_pkg::stat_type stat,
   output tsg_pkg::cmd_type  cmd
);

   tsg_pkg::fsm_type state_ff, state_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tsg_pkg::FSM_IDLE: begin
            if (req_valid) state_in = tsg_pkg::FSM_DECODE;
         end
         tsg_pkg::FSM_DECODE: begin
            unique case (stat.sym_class)
               tsg_pkg::CLS_PUSH: begin
                  state_in = stat.stack_full ? tsg_pkg::FSM_EMIT : tsg_pkg::FSM_IDLE;
               end
               tsg_pkg::CLS_POP: begin
                  state_in = stat.stack_empty ? tsg_pkg::FSM_EMIT : tsg_pkg::FSM_POP_WAIT;
               end
               tsg_pkg::CLS_MOVE: state_in = tsg_pkg::FSM_CORDIC;
               default:           state_in = tsg_pkg::FSM_IDLE;
            endcase
         end
         tsg_pkg::FSM_POP_WAIT: state_in = tsg_pkg::FSM_IDLE;
         tsg_pkg::FSM_CORDIC: begin
            if (stat.cordic_last) state_in = tsg_pkg::FSM_MUL_X;
         end
         tsg_pkg::FSM_MUL_X: state_in = tsg_pkg::FSM_MUL_Y;
         tsg_pkg::FSM_MUL_Y: state_in = tsg_pkg::FSM_ROUND;
         tsg_pkg::FSM_ROUND: state_in = tsg_pkg::FSM_EMIT;
         tsg_pkg::FSM_EMIT: begin
            if (out_free) state_in = tsg_pkg::FSM_IDLE;
         end
         default: state_in = tsg_pkg::FSM_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         tsg_pkg::FSM_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
         end
         tsg_pkg::FSM_DECODE: begin
            cmd.head_inc    = (stat.sym_class == tsg_pkg::CLS_LEFT);
            cmd.head_dec    = (stat.sym_class == tsg_pkg::CLS_RIGHT);
            cmd.push        = (stat.sym_class == tsg_pkg::CLS_PUSH) && !stat.stack_full;
            cmd.pop_rd      = (stat.sym_class == tsg_pkg::CLS_POP) && !stat.stack_empty;
            cmd.cordic_init = (stat.sym_class == tsg_pkg::CLS_MOVE);
         end
         tsg_pkg::FSM_POP_WAIT: cmd.pop_load = 1'b1;
         tsg_pkg::FSM_CORDIC:   cmd.cordic_step = 1'b1;
         tsg_pkg::FSM_MUL_X:    cmd.mul_x = 1'b1;
         tsg_pkg::FSM_MUL_Y:    cmd.mul_y = 1'b1;
         tsg_pkg::FSM_ROUND:    cmd.round_y = 1'b1;
         tsg_pkg::FSM_EMIT:     cmd.load_out = out_free;
         default: ;
      endcase
   end

   assign rsp_valid_in = cmd.load_out || (rsp_valid_ff && !rsp_ready);
   assign rsp_valid    = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tsg_pkg::FSM_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> (!rsp_valid_ff || rsp_ready))
      else $error("result register overwritten");

   a_accept_decode: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == tsg_pkg::FSM_DECODE))
      else $error("accepted item not decoded");

   a_cordic_exit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == tsg_pkg::FSM_CORDIC && stat.cordic_last) |=>
      (state_ff == tsg_pkg::FSM_MUL_X))
      else $error("CORDIC did not hand over to multiply");

   a_one_action: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.head_inc, cmd.head_dec, cmd.push, cmd.pop_rd, cmd.cordic_init}))
      else $error("several actions in one decode");

endmodule

### rtl/core/tsg_dp.sv
module tsg_dp (
   input  logic                clock,
   input  logic                reset,
   input  tsg_pkg::cmd_type    cmd,
   output tsg_pkg::stat_type   stat,
   input  logic [7:0]          req_symbol,
   input  logic                req_start_flag,
   input  logic [23:0]         step_length,
   input  logic [15:0]         turn_angle,
   output logic signed [31:0]  rsp_from_x,
   output logic signed [31:0]  rsp_from_y,
   output logic signed [31:0]  rsp_to_x,
   output logic signed [31:0]  rsp_to_y,
   output logic [1:0]          rsp_status
);

   logic [7:0]                        sym_ff;
   tsg_pkg::sym_class_type            sym_class;
   logic signed [31:0]                pos_x_ff, pos_x_in, pos_y_ff, pos_y_in;
   logic [15:0]                       heading_ff, heading_in;
   logic [tsg_pkg::LVL_W-1:0]         level_ff, level_in;
   logic [1:0]                        err_ff;
   logic signed [tsg_pkg::CW-1:0]     cx_ff, cx_in, cy_ff, cy_in, cz_ff, cz_in;
   logic [1:0]                        quad_ff;
   logic [tsg_pkg::STEP_W-1:0]        step_ff, step_in;
   logic signed [tsg_pkg::PROD_W-1:0] prod_ff;
   logic signed [tsg_pkg::CW-1:0]     dx_ff, dy_ff, rnd;
   logic signed [tsg_pkg::CW-1:0]     c_val, s_val, mul_op, sx, sy;
   logic signed [31:0]                to_x, to_y;
   logic [tsg_pkg::LVL_W-1:0]         level_dec;
   logic [15:0]                       hq, resid;
   logic [tsg_pkg::ENTRY_W-1:0]       rd_entry;
   logic [31:0]                       atan_v;
   logic [31:0]                       rsp_fx_ff, rsp_fy_ff, rsp_tx_ff, rsp_ty_ff;
   logic [1:0]                        rsp_st_ff;

   function automatic logic signed [31:0] sat_add(input logic signed [31:0] p,
                                                  input logic signed [tsg_pkg::CW-1:0] d);
      logic signed [tsg_pkg::CW:0] sum;
      sum = tsg_pkg::CW'(p) + d;
      if (sum > (tsg_pkg::CW + 1)'(32'sh7FFFFFFF)) return 32'sh7FFFFFFF;
      if (sum < -(tsg_pkg::CW + 1)'(33'sh080000000)) return 32'sh80000000;
      return sum[31:0];
   endfunction

   always_comb begin
      unique case (sym_ff)
         tsg_pkg::SYM_LEFT:  sym_class = tsg_pkg::CLS_LEFT;
         tsg_pkg::SYM_RIGHT: sym_class = tsg_pkg::CLS_RIGHT;
         tsg_pkg::SYM_PUSH:  sym_class = tsg_pkg::CLS_PUSH;
         tsg_pkg::SYM_POP:   sym_class = tsg_pkg::CLS_POP;
         tsg_pkg::SYM_SPACE: sym_class = tsg_pkg::CLS_SPACE;
         default:            sym_class = tsg_pkg::CLS_MOVE;
      endcase
   end
   assign stat = {sym_class,
                  level_ff == tsg_pkg::LVL_W'(tsg_pkg::STACK_DEPTH),
                  level_ff == '0,
                  step_ff == tsg_pkg::STEP_W'(tsg_pkg::CORDIC_STEPS - 1)};

   assign level_dec = level_ff - 1'b1;

   tsg_ram #(.WIDTH(tsg_pkg::ENTRY_W), .DEPTH(tsg_pkg::STACK_DEPTH)) u_stack (
      .clock   (clock),
      .wr_en   (cmd.push),
      .wr_addr (level_ff[tsg_pkg::SADDR_W-1:0]),
      .wr_data ({pos_x_ff, pos_y_ff, heading_ff}),
      .rd_addr (level_dec[tsg_pkg::SADDR_W-1:0]),
      .rd_data (rd_entry)
   );

   // quadrant split: residue of the heading lies within plus or minus an eighth turn
   assign hq     = heading_ff + 16'h2000;
   assign resid  = heading_ff - {hq[15:14], 14'b0};
   assign atan_v = tsg_pkg::atan_lookup(step_ff);
   assign sx     = cx_ff >>> step_ff;
   assign sy     = cy_ff >>> step_ff;

   always_comb begin
      unique case (quad_ff)
         2'd0: begin c_val = cx_ff;  s_val = cy_ff;  end
         2'd1: begin c_val = -cy_ff; s_val = cx_ff;  end
         2'd2: begin c_val = -cx_ff; s_val = -cy_ff; end
         default: begin c_val = cy_ff; s_val = -cx_ff; end
      endcase
      mul_op = cmd.mul_x ? c_val : s_val;
   end

   assign rnd  = tsg_pkg::CW'((prod_ff + tsg_pkg::PROD_W'(64'sd536870912)) >>> 30);
   assign to_x = (err_ff == tsg_pkg::ST_SEGMENT) ? sat_add(pos_x_ff, dx_ff) : pos_x_ff;
   assign to_y = (err_ff == tsg_pkg::ST_SEGMENT) ? sat_add(pos_y_ff, dy_ff) : pos_y_ff;

   always_comb begin
      pos_x_in   = pos_x_ff;
      pos_y_in   = pos_y_ff;
      heading_in = heading_ff;
      level_in   = level_ff;
      cx_in      = cx_ff;
      cy_in      = cy_ff;
      cz_in      = cz_ff;
      step_in    = step_ff;
      priority if (cmd.accept && req_start_flag) begin
         pos_x_in   = '0;
         pos_y_in   = '0;
         heading_in = tsg_pkg::HEADING_RESET;
         level_in   = '0;
      end else if (cmd.head_inc) begin
         heading_in = heading_ff + turn_angle;
      end else if (cmd.head_dec) begin
         heading_in = heading_ff - turn_angle;
      end else if (cmd.push) begin
         level_in = level_ff + 1'b1;
      end else if (cmd.pop_rd) begin
         level_in = level_dec;
      end else if (cmd.pop_load) begin
         {pos_x_in, pos_y_in, heading_in} = rd_entry;
      end else if (cmd.cordic_init) begin
         cx_in   = tsg_pkg::GAIN_Q30;
         cy_in   = '0;
         cz_in   = tsg_pkg::CW'($signed({resid, 16'b0}));
         step_in = '0;
      end else if (cmd.cordic_step) begin
         if (!cz_ff[tsg_pkg::CW-1]) begin
            cx_in = cx_ff - sy;
            cy_in = cy_ff + sx;
            cz_in = cz_ff - tsg_pkg::CW'(atan_v);
         end else begin
            cx_in = cx_ff + sy;
            cy_in = cy_ff - sx;
            cz_in = cz_ff + tsg_pkg::CW'(atan_v);
         end
         step_in = step_ff + 1'b1;
      end else if (cmd.load_out && err_ff == tsg_pkg::ST_SEGMENT) begin
         pos_x_in = to_x;
         pos_y_in = to_y;
      end else begin
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_x_ff   <= '0;
         pos_y_ff   <= '0;
         heading_ff <= tsg_pkg::HEADING_RESET;
         level_ff   <= '0;
      end else begin
         pos_x_ff   <= pos_x_in;
         pos_y_ff   <= pos_y_in;
         heading_ff <= heading_in;
         level_ff   <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      cx_ff   <= cx_in;
      cy_ff   <= cy_in;
      cz_ff   <= cz_in;
      step_ff <= step_in;
      if (cmd.accept) sym_ff <= req_symbol;
      if (cmd.cordic_init) begin
         quad_ff <= hq[15:14];
         err_ff  <= tsg_pkg::ST_SEGMENT;
      end
      if (cmd.push == 1'b0 && stat.sym_class == tsg_pkg::CLS_PUSH && stat.stack_full)
         err_ff <= tsg_pkg::ST_OVERFLOW;
      if (cmd.pop_rd == 1'b0 && stat.sym_class == tsg_pkg::CLS_POP && stat.stack_empty)
         err_ff <= tsg_pkg::ST_UNDERFLOW;
      if (cmd.mul_x || cmd.mul_y) prod_ff <= $signed({1'b0, step_length}) * mul_op;
      if (cmd.mul_y) dx_ff <= rnd;
      if (cmd.round_y) dy_ff <= rnd;
      if (cmd.load_out) begin
         rsp_fx_ff <= pos_x_ff;
         rsp_fy_ff <= pos_y_ff;
         rsp_tx_ff <= to_x;
         rsp_ty_ff <= to_y;
         rsp_st_ff <= err_ff;
      end
   end

   assign rsp_from_x = rsp_fx_ff;
   assign rsp_from_y = rsp_fy_ff;
   assign rsp_to_x   = rsp_tx_ff;
   assign rsp_to_y   = rsp_ty_ff;
   assign rsp_status = rsp_st_ff;

endmodule

### rtl/core/turtle_segment_generator_core.sv
// channel   direction  handshake            payload
// req       in         req_valid/req_ready  req_symbol, req_start_flag
// rsp       out        rsp_valid/rsp_ready  rsp_from_x/y, rsp_to_x/y, rsp_status
// csr       in         psel/penable/pwrite  step_length at 0, turn_angle at 4
//
// A forward move runs accept, decode, 16 CORDIC iterations on the
// shared shift-add unit, two multiplies on one multiplier, round, output.
// Turns, pushes and spaces end after decode; a pop adds a stack read, a stack error an output.
// Reset is synchronous; the stack RAM needs no clearing, the level is zeroed.
// One result register: the next item is taken while a result waits, and only
// the output cycle holds until rsp_ready frees the register.
module turtle_segment_generator_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_symbol,
   input  logic               req_start_flag,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_from_x,
   output logic signed [31:0] rsp_from_y,
   output logic signed [31:0] rsp_to_x,
   output logic signed [31:0] rsp_to_y,
   output logic [1:0]         rsp_status,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [2:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);

   tsg_pkg::cmd_type  cmd;
   tsg_pkg::stat_type stat;
   logic [23:0]       step_length_ff, step_length_in;
   logic [15:0]       turn_angle_ff, turn_angle_in;
   logic              wr;

   assign csr_pready = 1'b1;
   assign wr = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      step_length_in = step_length_ff;
      turn_angle_in  = turn_angle_ff;
      if (wr && csr_paddr[2] == tsg_pkg::REG_STEP_LENGTH) step_length_in = csr_pwdata[23:0];
      if (wr && csr_paddr[2] == tsg_pkg::REG_TURN_ANGLE)  turn_angle_in  = csr_pwdata[15:0];
      unique case (csr_paddr[2])
         tsg_pkg::REG_STEP_LENGTH: csr_prdata = {8'b0, step_length_ff};
         default:                  csr_prdata = {16'b0, turn_angle_ff};
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_length_ff <= tsg_pkg::STEP_RESET;
         turn_angle_ff  <= tsg_pkg::TURN_RESET;
      end else begin
         step_length_ff <= step_length_in;
         turn_angle_ff  <= turn_angle_in;
      end
   end

   tsg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   tsg_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .req_symbol     (req_symbol),
      .req_start_flag (req_start_flag),
      .step_length    (step_length_ff),
      .turn_angle     (turn_angle_ff),
      .rsp_from_x     (rsp_from_x),
      .rsp_from_y     (rsp_from_y),
      .rsp_to_x       (rsp_to_x),
      .rsp_to_y       (rsp_to_y),
      .rsp_status     (rsp_status)
   );

endmodule

### tb/tb.sv
`timescale 1ns / 100ps

module tb;

   localparam int CYCLE_LIMIT = 600000;
   localparam int DRAIN_WAIT  = 40;

   typedef struct {
      logic [7:0] sym;
      logic       start;
   } turtle_cmd_type;

   typedef struct {
      logic signed [31:0] from_x;
      logic signed [31:0] from_y;
      logic signed [31:0] to_x;
      logic signed [31:0] to_y;
      logic [1:0]         status;
   } segment_type;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic [7:0]         req_symbol;
   logic               req_start_flag;
   logic               rsp_valid;
   logic               rsp_ready;
   logic signed [31:0] rsp_from_x;
   logic signed [31:0] rsp_from_y;
   logic signed [31:0] rsp_to_x;
   logic signed [31:0] rsp_to_y;
   logic [1:0]         rsp_status;
   logic               csr_psel;
   logic               csr_penable;
   logic               csr_pwrite;
   logic [2:0]         csr_paddr;
   logic [31:0]        csr_pwdata;
   logic [31:0]        csr_prdata;
   logic               csr_pready;

   turtle_segment_generator_core u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_symbol(req_symbol), .req_start_flag(req_start_flag),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_from_x(rsp_from_x), .rsp_from_y(rsp_from_y),
      .rsp_to_x(rsp_to_x), .rsp_to_y(rsp_to_y), .rsp_status(rsp_status),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata), .csr_pready(csr_pready)
   );

   // turtle state mirror
   logic [23:0]        step_len;
   logic [15:0]        turn_amt;
   logic signed [31:0] turtle_x;
   logic signed [31:0] turtle_y;
   logic [15:0]        turtle_dir;
   logic signed [31:0] saved_x [tsg_pkg::STACK_DEPTH];
   logic signed [31:0] saved_y [tsg_pkg::STACK_DEPTH];
   logic [15:0]        saved_dir [tsg_pkg::STACK_DEPTH];
   int                 depth_used;

   longint angle_tab [0:15] = '{
      64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
      64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
      64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
      64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D};

   turtle_cmd_type pending_cmds [$];
   segment_type    expected_segs [$];
   int          n_issued = 0;
   int          n_accepted = 0;
   int          gap_left = 0;
   int          burst_left = 0;
   int          errors = 0;
   int          n_moves = 0;
   int          n_overflows = 0;
   int          n_underflows = 0;
   int          cycles = 0;
   logic [15:0] stall_pattern = 16'hFFFF;
   int          stall_phase = 0;

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   function automatic logic signed [31:0] clamp32(input longint v);
      if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

   task automatic push_segment(input logic signed [31:0] fx, fy, tx, ty,
                               input logic [1:0] st);
      segment_type s;
      s.from_x = fx;
      s.from_y = fy;
      s.to_x   = tx;
      s.to_y   = ty;
      s.status = st;
      expected_segs.push_back(s);
   endtask

   task automatic advance_turtle(input logic [7:0] sym, input logic start);
      int unsigned hh;
      int          q, i;
      longint      r, x, y, z, nx, ny, c, s, dx, dy;
      logic signed [31:0] ox, oy;
      if (start) begin
         turtle_x   = 0;
         turtle_y   = 0;
         turtle_dir = tsg_pkg::HEADING_RESET;
         depth_used = 0;
      end
      if (sym == tsg_pkg::SYM_LEFT) turtle_dir = turtle_dir + turn_amt;
      else if (sym == tsg_pkg::SYM_RIGHT) turtle_dir = turtle_dir - turn_amt;
      else if (sym == tsg_pkg::SYM_PUSH) begin
         if (depth_used >= tsg_pkg::STACK_DEPTH) begin
            push_segment(turtle_x, turtle_y, turtle_x, turtle_y, tsg_pkg::ST_OVERFLOW);
            n_overflows++;
         end else begin
            saved_x[depth_used]   = turtle_x;
            saved_y[depth_used]   = turtle_y;
            saved_dir[depth_used] = turtle_dir;
            depth_used++;
         end
      end else if (sym == tsg_pkg::SYM_POP) begin
         if (depth_used == 0) begin
            push_segment(turtle_x, turtle_y, turtle_x, turtle_y, tsg_pkg::ST_UNDERFLOW);
            n_underflows++;
         end else begin
            depth_used--;
            turtle_x   = saved_x[depth_used];
            turtle_y   = saved_y[depth_used];
            turtle_dir = saved_dir[depth_used];
         end
      end else if (sym != tsg_pkg::SYM_SPACE) begin
         // split heading into quadrant and signed residue, then rotate
         hh = turtle_dir;
         q  = ((hh + 8192) >> 14) & 3;
         r  = longint'(hh) - q * 16384;
         if (r >= 32768) r = r - 65536;
         x = 652032874;
         y = 0;
         z = r * 65536;
         for (i = 0; i < tsg_pkg::CORDIC_STEPS; i++) begin
            if (z >= 0) begin
               nx = x - (y >>> i);
               ny = y + (x >>> i);
               z  = z - angle_tab[i];
            end else begin
               nx = x + (y >>> i);
               ny = y - (x >>> i);
               z  = z + angle_tab[i];
            end
            x = nx;
            y = ny;
         end
         case (q)
            0: begin c = x;  s = y;  end
            1: begin c = -y; s = x;  end
            2: begin c = -x; s = -y; end
            default: begin c = y; s = -x; end
         endcase
         dx = (longint'(step_len) * c + (64'sd1 <<< 29)) >>> 30;
         dy = (longint'(step_len) * s + (64'sd1 <<< 29)) >>> 30;
         ox = turtle_x;
         oy = turtle_y;
         turtle_x = clamp32(longint'(turtle_x) + dx);
         turtle_y = clamp32(longint'(turtle_y) + dy);
         push_segment(ox, oy, turtle_x, turtle_y, tsg_pkg::ST_SEGMENT);
         n_moves++;
      end
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] got, exp);
      $display("mismatch %s: got %h expected %h at cycle %0d", what, got, exp, cycles);
      errors++;
   endtask

   // driver: bursts of transfers separated by random gaps
   always @(negedge clock) begin
      turtle_cmd_type it;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && n_issued != n_accepted) begin
         // hold until the transfer completes
      end else if (gap_left > 0) begin
         gap_left--;
         req_valid <= 1'b0;
      end else if (pending_cmds.size() > 0) begin
         it = pending_cmds.pop_front();
         req_symbol     <= it.sym;
         req_start_flag <= it.start;
         req_valid      <= 1'b1;
         n_issued++;
         if (burst_left > 0) begin
            burst_left--;
         end else begin
            burst_left = $urandom_range(0, 40);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         end
      end else begin
         req_valid <= 1'b0;
      end
   end

   // receiver stall pattern, renewed when the phase counter wraps
   always @(negedge clock) begin
      if (stall_phase == 0) begin
         case ($urandom_range(0, 3))
            0: stall_pattern = 16'hFFFF;
            1: stall_pattern = 16'h0001;
            default: stall_pattern = 16'($urandom);
         endcase
      end
      stall_phase = (stall_phase + 1) % 32;
      rsp_ready <= reset ? 1'b0 : stall_pattern[stall_phase % 16];
   end

   always @(posedge clock) begin
      segment_type e;
      if (!reset) begin
         if (req_valid && req_ready) begin
            advance_turtle(req_symbol, req_start_flag);
            n_accepted++;
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_segs.size() == 0) begin
               report_mismatch("unexpected result", {30'd0, rsp_status}, 32'd0);
            end else begin
               e = expected_segs.pop_front();
               if (rsp_from_x !== e.from_x) report_mismatch("from_x", rsp_from_x, e.from_x);
               if (rsp_from_y !== e.from_y) report_mismatch("from_y", rsp_from_y, e.from_y);
               if (rsp_to_x !== e.to_x) report_mismatch("to_x", rsp_to_x, e.to_x);
               if (rsp_to_y !== e.to_y) report_mismatch("to_y", rsp_to_y, e.to_y);
               if (rsp_status !== e.status)
                  report_mismatch("status", {30'd0, rsp_status}, {30'd0, e.status});
            end
         end
      end
   end

   task automatic queue_cmd(input logic [7:0] sym, input logic start);
      turtle_cmd_type c;
      c.sym   = sym;
      c.start = start;
      pending_cmds.push_back(c);
   endtask

   function automatic logic [7:0] any_move_byte();
      logic [7:0] b;
      do b = 8'($urandom);
      while (b == tsg_pkg::SYM_LEFT || b == tsg_pkg::SYM_RIGHT || b == tsg_pkg::SYM_PUSH ||
             b == tsg_pkg::SYM_POP || b == tsg_pkg::SYM_SPACE);
      return b;
   endfunction

   task automatic wait_quiet();
      while (pending_cmds.size() > 0 || n_issued != n_accepted || expected_segs.size() > 0)
         @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic csr_write(input logic idx, input logic [31:0] data);
      logic [31:0] exp_rd;
      @(negedge clock);
      csr_psel    = 1'b1;
      csr_pwrite  = 1'b1;
      csr_penable = 1'b0;
      csr_paddr   = {idx, 2'b00};
      csr_pwdata  = data;
      @(negedge clock);
      csr_penable = 1'b1;
      @(posedge clock);
      if (idx == tsg_pkg::REG_STEP_LENGTH) step_len = data[23:0];
      else turn_amt = data[15:0];
      @(negedge clock);
      exp_rd = (idx == tsg_pkg::REG_STEP_LENGTH) ? {8'd0, step_len} : {16'd0, turn_amt};
      if (csr_pready !== 1'b1) report_mismatch("pready", {31'd0, csr_pready}, 32'd1);
      if (csr_prdata !== exp_rd) report_mismatch("readback", csr_prdata, exp_rd);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
   endtask

   task automatic random_phase(input int count);
      int k, n, j;
      k = 0;
      while (k < count) begin
         n = $urandom_range(0, 99);
         if (n < 70) begin
            // well-formed branch with random body
            queue_cmd(tsg_pkg::SYM_PUSH, 1'b0);
            repeat ($urandom_range(1, 8)) begin
               case ($urandom_range(0, 5))
                  0: queue_cmd(tsg_pkg::SYM_LEFT, 1'b0);
                  1: queue_cmd(tsg_pkg::SYM_RIGHT, 1'b0);
                  2: queue_cmd(tsg_pkg::SYM_SPACE, 1'b0);
                  default: queue_cmd(any_move_byte(), 1'b0);
               endcase
               k++;
            end
            queue_cmd(tsg_pkg::SYM_POP, 1'b0);
            k += 2;
         end else if (n < 73) begin
            // deep nesting, at times into overflow, then past empty
            j = $urandom_range(60, 68);
            repeat (j) queue_cmd(tsg_pkg::SYM_PUSH, 1'b0);
            repeat (j + 2) queue_cmd(tsg_pkg::SYM_POP, 1'b0);
            k += 2 * j + 2;
         end else begin
            queue_cmd(($urandom_range(0, 1) == 0) ? any_move_byte() : 8'($urandom),
                      $urandom_range(0, 7) == 0);
            k++;
         end
      end
      wait_quiet();
   endtask

   initial begin
      req_valid      = 1'b0;
      req_symbol     = 8'h00;
      req_start_flag = 1'b0;
      rsp_ready      = 1'b0;
      csr_psel       = 1'b0;
      csr_penable    = 1'b0;
      csr_pwrite     = 1'b0;
      csr_paddr      = 3'd0;
      csr_pwdata     = 32'd0;
      step_len       = tsg_pkg::STEP_RESET;
      turn_amt       = tsg_pkg::TURN_RESET;
      turtle_x       = 0;
      turtle_y       = 0;
      turtle_dir     = tsg_pkg::HEADING_RESET;
      depth_used     = 0;
      reset          = 1'b1;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: reset values, every command, both stack errors, start flag
      queue_cmd(8'h46, 1'b0);
      queue_cmd(tsg_pkg::SYM_POP, 1'b0);
      queue_cmd(tsg_pkg::SYM_LEFT, 1'b0);
      queue_cmd(8'h00, 1'b0);
      queue_cmd(tsg_pkg::SYM_RIGHT, 1'b0);
      queue_cmd(tsg_pkg::SYM_RIGHT, 1'b0);
      queue_cmd(8'hFF, 1'b0);
      queue_cmd(tsg_pkg::SYM_SPACE, 1'b0);
      queue_cmd(tsg_pkg::SYM_PUSH, 1'b0);
      queue_cmd(8'h41, 1'b0);
      queue_cmd(tsg_pkg::SYM_POP, 1'b0);
      queue_cmd(8'h46, 1'b1);
      queue_cmd(tsg_pkg::SYM_PUSH, 1'b0);
      queue_cmd(tsg_pkg::SYM_PUSH, 1'b1);
      queue_cmd(tsg_pkg::SYM_POP, 1'b0);
      queue_cmd(tsg_pkg::SYM_POP, 1'b0);
      repeat (tsg_pkg::STACK_DEPTH + 1) queue_cmd(tsg_pkg::SYM_PUSH, 1'b0);
      queue_cmd(8'h80, 1'b1);
      wait_quiet();

      random_phase(250);
      csr_write(tsg_pkg::REG_STEP_LENGTH, 32'hFFFFFF);
      csr_write(tsg_pkg::REG_TURN_ANGLE, 32'd0);
      random_phase(300);
      csr_write(tsg_pkg::REG_STEP_LENGTH, 32'd0);
      csr_write(tsg_pkg::REG_TURN_ANGLE, 32'hFFFF);
      random_phase(200);
      csr_write(tsg_pkg::REG_STEP_LENGTH, 32'd1);
      csr_write(tsg_pkg::REG_TURN_ANGLE, 32'd16384);
      random_phase(250);
      csr_write(tsg_pkg::REG_STEP_LENGTH, 32'hFFFFFF);
      csr_write(tsg_pkg::REG_TURN_ANGLE, 32'd32768);
      random_phase(250);
      repeat (2) begin
         csr_write(tsg_pkg::REG_STEP_LENGTH, $urandom_range(0, 32'hFFFFFF));
         csr_write(tsg_pkg::REG_TURN_ANGLE, $urandom_range(0, 32'hFFFF));
         random_phase(250);
      end

      if (expected_segs.size() > 0) begin
         $display("%0d expected results never arrived", expected_segs.size());
         errors++;
      end
      $display("covered %0d commands: %0d segments, %0d overflows, %0d underflows",
               n_accepted, n_moves, n_overflows, n_underflows);
      if (errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

### filelist.f
rtl/core/tsg_pkg.sv
rtl/core/tsg_ram.sv
rtl/core/tsg_ctrl.sv
rtl/core/tsg_dp.sv
rtl/core/turtle_segment_generator_core.sv
tb/tb.sv
